// ===== sv/wbss_pkg.sv =====
// wbss_pkg: request and result types, register indexes and fixed widths
// for the wildcard byte signature scanner; no dependencies
`timescale 1ns / 1ps

package wbss_pkg;

   localparam int ADDR_BITS   = 48;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [CSR_IDX_BITS-1:0] REG_PATTERN_LOW  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_PATTERN_HIGH = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_WILDCARD     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_LENGTH       = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_OCCURRENCE   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_BASE         = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_OFFSET       = 3'd6;

   localparam logic [3:0]  NIBBLE_MASK = 4'hF;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [ADDR_BITS-1:0] match_address;
   } rsp_type;

endpackage

// ===== sv/wildcard_byte_signature_scan_top.sv =====
// wildcard_byte_signature_scan_top: byte stream scanner for a nibble-wildcard
// pattern of up to PATTERN_BYTES bytes; depends on wbss_pkg
`timescale 1ns / 1ps

// Usage
//   req channel: one byte of the scanned region per request, last_byte marks
//   the final byte. A request is taken when req_valid is high and req_stall low.
//   rsp channel: at most one result per region, either found with the match
//   address (base + match start + offset, modulo 2^48) or not found with a
//   zero address when the region ends first. Bytes after a report are consumed
//   with no result; the region's scan state clears after the last byte.
//   csr channel: register writes by index, always ready; write only while idle.
// Result: the result of a request is registered and is on rsp in the cycle after it is taken.
// Throughput: one byte per cycle while req_stall is low; the window compare of all pattern bytes
//   against the shifted byte window is done in the accepting cycle.
// Stall: a waiting result is held in the output register; req_stall is raised
//   only while that result is waiting and rsp_stall is high.
// Reset: synchronous; clears the configuration registers, counters and the output valid.
//   The byte window and the output payload hold no reset value; the window is qualified by its fill.

module wildcard_byte_signature_scan_top #(
   parameter int PATTERN_BYTES = 16,
   parameter int POSITION_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  wbss_pkg::req_type                      req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output wbss_pkg::rsp_type                      rsp_payload,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [wbss_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [wbss_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   localparam int LW = $clog2(PATTERN_BYTES + 1);
   localparam int IW = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
   localparam int AW = wbss_pkg::ADDR_BITS;
   localparam logic [4:0]    LEN_MAX  = 5'(PATTERN_BYTES);
   localparam logic [LW-1:0] FILL_MAX = LW'(PATTERN_BYTES);

   logic [63:0]             pattern_low_ff;
   logic [63:0]             pattern_high_ff;
   logic [31:0]             wildcard_ff;
   logic [4:0]              length_ff;
   logic [15:0]             occurrence_ff;
   logic [AW-1:0]           base_ff;
   logic [31:0]             offset_ff;

   logic [7:0]              window_ff [PATTERN_BYTES];
   logic [7:0]              window_in [PATTERN_BYTES];
   logic [LW-1:0]           fill_ff;
   logic [LW-1:0]           fill_in;
   logic [POSITION_BITS-1:0] seen_ff;
   logic [POSITION_BITS-1:0] seen_in;
   logic [15:0]             count_ff;
   logic                    reported_ff;

   logic                    rsp_valid_ff;
   wbss_pkg::rsp_type       rsp_ff;

   logic                    req_fire;
   logic                    rsp_take;
   logic [LW-1:0]           len_eff;
   logic [127:0]            pattern_all;
   logic                    hit;
   logic                    report;
   logic                    give_not_found;
   logic [POSITION_BITS-1:0] position;
   logic [AW-1:0]           address;

   function automatic logic byte_ok(input logic [7:0] data, input logic [7:0] want,
                                    input logic hi_wild, input logic lo_wild);
      logic hi_ok;
      logic lo_ok;
      hi_ok = hi_wild || ((data[7:4] & wbss_pkg::NIBBLE_MASK) ==
                          (want[7:4] & wbss_pkg::NIBBLE_MASK));
      lo_ok = lo_wild || ((data[3:0] & wbss_pkg::NIBBLE_MASK) ==
                          (want[3:0] & wbss_pkg::NIBBLE_MASK));
      return hi_ok && lo_ok;
   endfunction

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready = 1'b1;

   assign len_eff     = (length_ff > LEN_MAX) ? FILL_MAX : length_ff[LW-1:0];
   assign pattern_all = {pattern_high_ff, pattern_low_ff};
   assign fill_in     = (fill_ff == FILL_MAX) ? fill_ff : fill_ff + LW'(1);
   assign seen_in     = seen_ff + POSITION_BITS'(1);

   always_comb begin
      window_in[0] = req_payload.data_byte;
      for (int j = 1; j < PATTERN_BYTES; j++) begin
         window_in[j] = window_ff[j-1];
      end
   end

   // pattern byte i lines up with window slot len-1-i
   always_comb begin
      logic [LW-1:0] slot;
      hit = (len_eff != '0) && (fill_in >= len_eff);
      for (int i = 0; i < PATTERN_BYTES; i++) begin
         slot = len_eff - LW'(1) - LW'(i);
         if (LW'(i) < len_eff) begin
            if (!byte_ok(window_in[slot[IW-1:0]], pattern_all[8*i +: 8],
                         wildcard_ff[2*i], wildcard_ff[2*i+1])) begin
               hit = 1'b0;
            end
         end
      end
   end

   assign report = hit && ((occurrence_ff == '0) || (count_ff == occurrence_ff));
   assign give_not_found = req_payload.last_byte && !report;
   assign position = seen_in - POSITION_BITS'(len_eff);
   assign address  = base_ff + AW'(position) + AW'(offset_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         wildcard_ff     <= '0;
         length_ff       <= '0;
         occurrence_ff   <= '0;
         base_ff         <= '0;
         offset_ff       <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            wbss_pkg::REG_PATTERN_LOW:  pattern_low_ff  <= csr_data;
            wbss_pkg::REG_PATTERN_HIGH: pattern_high_ff <= csr_data;
            wbss_pkg::REG_WILDCARD:     wildcard_ff     <= csr_data[31:0];
            wbss_pkg::REG_LENGTH:       length_ff       <= csr_data[4:0];
            wbss_pkg::REG_OCCURRENCE:   occurrence_ff   <= csr_data[15:0];
            wbss_pkg::REG_BASE:         base_ff         <= csr_data[AW-1:0];
            wbss_pkg::REG_OFFSET:       offset_ff       <= csr_data[31:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && !reported_ff) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         seen_ff     <= '0;
         count_ff    <= '0;
         reported_ff <= 1'b0;
      end else if (req_fire) begin
         if (req_payload.last_byte) begin
            fill_ff     <= '0;
            seen_ff     <= '0;
            count_ff    <= '0;
            reported_ff <= 1'b0;
         end else if (!reported_ff) begin
            fill_ff <= fill_in;
            seen_ff <= seen_in;
            if (report) begin
               reported_ff <= 1'b1;
            end else if (hit && (count_ff != wbss_pkg::COUNT_MAX)) begin
               count_ff <= count_ff + 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && !reported_ff && (report || give_not_found)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && !reported_ff && (report || give_not_found)) begin
         rsp_ff.found         <= report;
         rsp_ff.match_address <= report ? address : '0;
      end
   end

endmodule

// ===== sv/wbss_checker.sv =====
// wbss_checker: port-level assertions for the signature scanner and the bind
// that attaches them to wildcard_byte_signature_scan_top; depends on wbss_pkg
`timescale 1ns / 1ps

module wbss_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input wbss_pkg::rsp_type rsp_payload
);

   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // no request taken while a result is blocked
   a_req_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request accepted while result is blocked");

   // not-found results carry a zero address
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.found |-> rsp_payload.match_address == '0)
      else $error("not-found result with nonzero address");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stall only while a result waits
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no waiting result");

endmodule

bind wildcard_byte_signature_scan_top wbss_checker u_wbss_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ===== tb/sv/testbench.sv =====
// testbench: self-checking bench for wildcard_byte_signature_scan_top, with a bursty request
// driver, a stalling result side and a predictor of the scan kept in step with each request
// depends on wbss_pkg and the scanner rtl
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned TOTAL_ITEMS = 500;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   wbss_pkg::req_type                  req_payload = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   wbss_pkg::rsp_type                  rsp_payload;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [wbss_pkg::CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [wbss_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   // register copies
   logic [63:0] pat_lo = '0;
   logic [63:0] pat_hi = '0;
   logic [31:0] wild_mask = '0;
   logic [4:0]  pat_len = '0;
   logic [15:0] occ_sel = '0;
   logic [47:0] base_addr = '0;
   logic [31:0] res_offset = '0;

   // scan state copy
   logic [7:0]  win [16];
   int unsigned win_fill = 0;
   logic [31:0] seen_pos = '0;
   logic [15:0] skip_count = '0;
   bit          reported = 1'b0;

   wbss_pkg::req_type pending_req [$];
   wbss_pkg::rsp_type expected_rsp [$];
   wbss_pkg::rsp_type want_rsp;
   logic              req_taken = 1'b0;
   int unsigned       burst_left = 0;
   int unsigned       gap_left = 0;
   stall_mode_type    stall_mode = STALL_NONE;
   logic [7:0]        stall_phase = '0;
   int unsigned       items_queued = 0;
   int unsigned       scanned_items = 0;
   int unsigned       results_seen = 0;
   int unsigned       fail_count = 0;
   int unsigned       cycle_count = 0;

   wildcard_byte_signature_scan_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int unsigned eff_len();
      return (pat_len > 16) ? 16 : pat_len;
   endfunction

   function automatic logic [7:0] pat_byte(input int unsigned i);
      logic [127:0] both;
      both = {pat_hi, pat_lo};
      return both[8*i +: 8];
   endfunction

   function automatic void scan_predict(input wbss_pkg::req_type r);
      int unsigned       len;
      int unsigned       i;
      bit                hit;
      bit                emitted;
      logic [7:0]        want;
      logic [7:0]        got;
      logic [31:0]       pos;
      wbss_pkg::rsp_type res;
      len = eff_len();
      emitted = 1'b0;
      if (!reported) begin
         scanned_items++;
         for (i = 15; i > 0; i--) win[i] = win[i-1];
         win[0] = r.data_byte;
         if (win_fill < 16) win_fill++;
         seen_pos = seen_pos + 32'd1;
         if (len > 0 && win_fill >= len) begin
            hit = 1'b1;
            for (i = 0; i < len; i++) begin
               want = pat_byte(i);
               got = win[len-1-i];
               if (!wild_mask[2*i] && got[7:4] != want[7:4]) hit = 1'b0;
               if (!wild_mask[2*i+1] && got[3:0] != want[3:0]) hit = 1'b0;
            end
            if (hit) begin
               if (occ_sel == 16'd0 || skip_count == occ_sel) begin
                  pos = seen_pos - len;
                  res.found = 1'b1;
                  res.match_address = base_addr + {16'h0, pos} + {16'h0, res_offset};
                  expected_rsp = {expected_rsp, res};
                  reported = 1'b1;
                  emitted = 1'b1;
               end else if (skip_count != wbss_pkg::COUNT_MAX) begin
                  skip_count++;
               end
            end
         end
         if (r.last_byte && !emitted) begin
            res = '0;
            expected_rsp = {expected_rsp, res};
         end
      end
      if (r.last_byte) begin
         win_fill = 0;
         seen_pos = '0;
         skip_count = '0;
         reported = 1'b0;
      end
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
      end else if (gap_left > 0) begin
         gap_left <= gap_left - 1;
         req_valid <= 1'b0;
      end else if (pending_req.size() > 0) begin
         req_payload <= pending_req.pop_front();
         req_valid <= 1'b1;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result stall pattern
   always @(negedge clock) begin
      stall_phase <= stall_phase + 8'd1;
      if (stall_phase[5:0] == 6'd0) stall_mode <= stall_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 2) == 0);
         STALL_PERIODIC: rsp_stall <= (stall_phase[1:0] != 2'b00);
         default:        rsp_stall <= (stall_phase[4:3] == 2'b00);
      endcase
   end

   // monitor: check results, then predict from the request taken at this edge
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_rsp.size() == 0) begin
               $error("unexpected result: found=%0b match_address=%h",
                      rsp_payload.found, rsp_payload.match_address);
               fail_count++;
            end else begin
               want_rsp = expected_rsp.pop_front();
               if (rsp_payload.found !== want_rsp.found) begin
                  $error("found: expected %0b actual %0b", want_rsp.found, rsp_payload.found);
                  fail_count++;
               end
               if (rsp_payload.match_address !== want_rsp.match_address) begin
                  $error("match_address: expected %h actual %h",
                         want_rsp.match_address, rsp_payload.match_address);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) scan_predict(req_payload);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic write_reg(input logic [wbss_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [63:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         wbss_pkg::REG_PATTERN_LOW:  pat_lo = value;
         wbss_pkg::REG_PATTERN_HIGH: pat_hi = value;
         wbss_pkg::REG_WILDCARD:     wild_mask = value[31:0];
         wbss_pkg::REG_LENGTH:       pat_len = value[4:0];
         wbss_pkg::REG_OCCURRENCE:   occ_sel = value[15:0];
         wbss_pkg::REG_BASE:         base_addr = value[47:0];
         wbss_pkg::REG_OFFSET:       res_offset = value[31:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic push_byte(input logic [7:0] data, input logic last);
      wbss_pkg::req_type r;
      r.data_byte = data;
      r.last_byte = last;
      pending_req = {pending_req, r};
      items_queued++;
   endtask

   task automatic wait_idle();
      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // sometimes set bits above the register width
   function automatic logic [63:0] add_junk(input logic [63:0] value, input int unsigned width);
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) return value | (junk << width);
      return value;
   endfunction

   task automatic random_config();
      logic [63:0] lo;
      logic [63:0] hi;
      logic [31:0] mask;
      logic [4:0]  len;
      logic [15:0] occ;
      logic [47:0] base;
      logic [31:0] offs;
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: begin lo = '1; hi = '1; end
         1: begin lo = '0; hi = '0; end
         2: begin lo = {8{lo[7:0]}}; hi = {8{lo[7:0]}}; end
         default: ;
      endcase
      case ($urandom_range(0, 5))
         0: mask = '1;
         1: mask = $urandom;
         2, 3: mask = $urandom & $urandom & $urandom;
         default: mask = '0;
      endcase
      case ($urandom_range(0, 19))
         0: len = 5'd0;
         1: len = 5'd16;
         2: len = 5'($urandom_range(17, 31));
         3, 4, 5: len = 5'($urandom_range(5, 15));
         default: len = 5'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 9))
         0: occ = 16'd1;
         1, 2: occ = 16'($urandom_range(2, 5));
         3: occ = 16'($urandom);
         4: occ = 16'hFFFF;
         default: occ = 16'd0;
      endcase
      case ($urandom_range(0, 3))
         0: base = '0;
         1: base = '1;
         default: base = 48'({$urandom, $urandom});
      endcase
      case ($urandom_range(0, 3))
         0: offs = '0;
         1: offs = '1;
         default: offs = $urandom;
      endcase
      write_reg(wbss_pkg::REG_PATTERN_LOW, lo);
      write_reg(wbss_pkg::REG_PATTERN_HIGH, hi);
      write_reg(wbss_pkg::REG_WILDCARD, add_junk({32'h0, mask}, 32));
      write_reg(wbss_pkg::REG_LENGTH, add_junk({59'h0, len}, 5));
      write_reg(wbss_pkg::REG_OCCURRENCE, add_junk({48'h0, occ}, 16));
      write_reg(wbss_pkg::REG_BASE, add_junk({16'h0, base}, 48));
      write_reg(wbss_pkg::REG_OFFSET, add_junk({32'h0, offs}, 32));
   endtask

   // one region: pattern copies, broken copies and noise, last byte flagged
   task automatic make_region();
      logic [7:0]  bytes_q [$];
      logic [7:0]  b;
      int unsigned target;
      int unsigned len;
      int unsigned j;
      int unsigned broken_at;
      bit          noise_only;
      len = eff_len();
      target = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 24);
      noise_only = ($urandom_range(0, 7) == 0);
      while (bytes_q.size() < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               if (len > 0 && !noise_only) begin
                  broken_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len - 1) : len;
                  for (j = 0; j < len; j++) begin
                     b = pat_byte(j);
                     if (wild_mask[2*j]) b[7:4] = 4'($urandom);
                     if (wild_mask[2*j+1]) b[3:0] = 4'($urandom);
                     if (j == broken_at) b ^= 8'($urandom_range(1, 255));
                     bytes_q = {bytes_q, b};
                  end
               end else begin
                  bytes_q = {bytes_q, 8'($urandom)};
               end
            end
            4, 5, 6: begin
               b = (len > 0) ? pat_byte($urandom_range(0, len - 1)) : 8'($urandom);
               if ($urandom_range(0, 1) == 0) b[3:0] = 4'($urandom);
               bytes_q = {bytes_q, b};
            end
            default: bytes_q = {bytes_q, 8'($urandom)};
         endcase
      end
      for (j = 0; j < bytes_q.size(); j++) push_byte(bytes_q[j], j == bytes_q.size() - 1);
   endtask

   initial begin
      int unsigned phases;
      int unsigned k;
      phases = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero length after reset: not found on the last byte
      push_byte(8'h5A, 1'b1);
      wait_idle();

      // found, then bytes after the report ignored, then a match on the final byte
      write_reg(wbss_pkg::REG_PATTERN_LOW, 64'h0000_0000_0000_ADDE);
      write_reg(wbss_pkg::REG_PATTERN_HIGH, 64'h0);
      write_reg(wbss_pkg::REG_WILDCARD, 64'h0);
      write_reg(wbss_pkg::REG_LENGTH, 64'd2);
      write_reg(wbss_pkg::REG_OCCURRENCE, 64'd0);
      write_reg(wbss_pkg::REG_BASE, 64'h1000);
      write_reg(wbss_pkg::REG_OFFSET, 64'd5);
      push_byte(8'h00, 1'b0);
      push_byte(8'hDE, 1'b0);
      push_byte(8'hAD, 1'b0);
      push_byte(8'hAD, 1'b1);
      push_byte(8'hDE, 1'b0);
      push_byte(8'hAD, 1'b1);
      wait_idle();

      // length above the window, all nibbles wild, extreme bytes
      write_reg(wbss_pkg::REG_PATTERN_LOW, '1);
      write_reg(wbss_pkg::REG_WILDCARD, 64'hFFFF_FFFF);
      write_reg(wbss_pkg::REG_LENGTH, 64'd31);
      for (k = 0; k < 16; k++) push_byte((k % 2) ? 8'hFF : 8'h00, k == 15);
      wait_idle();

      // overlapping matches, occurrence one quirk, address wrap
      write_reg(wbss_pkg::REG_PATTERN_LOW, 64'h0000_0000_0000_AAAA);
      write_reg(wbss_pkg::REG_WILDCARD, 64'h0);
      write_reg(wbss_pkg::REG_LENGTH, 64'd2);
      write_reg(wbss_pkg::REG_OCCURRENCE, 64'd1);
      write_reg(wbss_pkg::REG_BASE, 64'hFFFF_FFFF_FFFF);
      write_reg(wbss_pkg::REG_OFFSET, 64'hFFFF_FFFF);
      push_byte(8'hAA, 1'b0);
      push_byte(8'hAA, 1'b0);
      push_byte(8'hAA, 1'b1);
      wait_idle();

      // every byte matches but the selected occurrence is never reached
      write_reg(wbss_pkg::REG_WILDCARD, 64'hFFFF_FFFF);
      write_reg(wbss_pkg::REG_LENGTH, 64'd1);
      write_reg(wbss_pkg::REG_OCCURRENCE, 64'hFFFF);
      write_reg(wbss_pkg::REG_BASE, 64'h0);
      write_reg(wbss_pkg::REG_OFFSET, 64'h0);
      for (k = 0; k < 20; k++) push_byte(8'($urandom), k == 19);
      wait_idle();

      while (items_queued < TOTAL_ITEMS) begin
         random_config();
         repeat ($urandom_range(1, 3)) make_region();
         wait_idle();
         phases++;
      end

      repeat (8) @(posedge clock);
      $display("sent %0d bytes (%0d scanned) over directed cases and %0d random settings",
               items_queued, scanned_items, phases);
      $display("checked %0d results, %0d mismatches", results_seen, fail_count);
      if (fail_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
